/* rtl/vrrq_pkg.sv */
// Shared types, codes and constants of the variable record ring queue.
package vrrq_pkg;

    // Field widths fixed by the transaction format.
    localparam int FUNC_W   = 3;
    localparam int HALF_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int PCOUNT_W = 11;
    localparam int BUSED_W  = 13;

    // Record header: identifier low/high, then length low/high.
    localparam int HEADER_BYTES = 4;
    localparam int HDR_IDX_W    = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_IBYTE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DIST  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RBYTE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOROOM = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_SEQ    = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR_WR,
        S_HDR_RD,
        S_HDR_LAST,
        S_DIST_COMMIT,
        S_BYTE_CAP,
        S_FIN
    } t_state;

    // Byte store access of the current cycle.
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_HDR_WR,
        MEM_BYTE_WR,
        MEM_HDR_RD,
        MEM_BYTE_RD
    } t_mem_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch;
        logic              res_init;
        logic [STAT_W-1:0] res_status;
        logic              ins_commit;
        t_mem_op           mem_op;
        logic              k_clr;
        logic              k_inc;
        logic              hdr_cap;
        logic              dist_wrap;
        logic              dist_commit;
        logic              byte_cap;
        logic              clear;
        logic              load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_pend;
        logic              rd_pend;
        logic              empty;
        logic              room_ok;
        logic              k_zero;
        logic              k_last;
    } t_stat;

endpackage

/* rtl/variable_record_ring_queue_core.sv */
// Each transaction runs an execute state, then a finish state that loads the result; begin insert
// adds header writes, distill adds header reads and a commit, read byte adds a byte capture.
// A new transaction is taken once the previous result has entered the output
// register, which may still be waiting; the single-port byte store sets the header steps.
// Reset (synchronous, active low) empties the queue; store contents stay undefined.
// Top level of the variable record ring queue.
module variable_record_ring_queue_core #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [vrrq_pkg::FUNC_W-1:0]   i_func,
    input  logic [vrrq_pkg::HALF_W-1:0]   i_identifier,
    input  logic [vrrq_pkg::HALF_W-1:0]   i_packet_length,
    input  logic [vrrq_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [vrrq_pkg::HALF_W-1:0]   i_reader_capacity,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [vrrq_pkg::STAT_W-1:0]   o_status,
    output logic [vrrq_pkg::HALF_W-1:0]   o_out_identifier,
    output logic [vrrq_pkg::HALF_W-1:0]   o_out_length,
    output logic [vrrq_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last,
    output logic [vrrq_pkg::PCOUNT_W-1:0] o_packet_count,
    output logic [vrrq_pkg::BUSED_W-1:0]  o_bytes_used
);

    vrrq_pkg::t_cmd  cmd;
    vrrq_pkg::t_stat stat;

    // Sequencer.
    vrrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Pointers, byte store and result registers.
    vrrq_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_identifier      (i_identifier),
        .i_packet_length   (i_packet_length),
        .i_data_byte       (i_data_byte),
        .i_reader_capacity (i_reader_capacity),
        .o_status          (o_status),
        .o_out_identifier  (o_out_identifier),
        .o_out_length      (o_out_length),
        .o_out_byte        (o_out_byte),
        .o_last            (o_last),
        .o_packet_count    (o_packet_count),
        .o_bytes_used      (o_bytes_used)
    );

endmodule

/* rtl/vrrq_ram.sv */
// Generic single-port RAM with registered read data.
module vrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write or registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vrrq_datapath.sv */
// Datapath: pointers, counters, room check, byte store and result registers.
module vrrq_datapath #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vrrq_pkg::t_cmd                 i_cmd,
    output vrrq_pkg::t_stat                o_stat,
    input  logic [vrrq_pkg::FUNC_W-1:0]    i_func,
    input  logic [vrrq_pkg::HALF_W-1:0]    i_identifier,
    input  logic [vrrq_pkg::HALF_W-1:0]    i_packet_length,
    input  logic [vrrq_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [vrrq_pkg::HALF_W-1:0]    i_reader_capacity,
    output logic [vrrq_pkg::STAT_W-1:0]    o_status,
    output logic [vrrq_pkg::HALF_W-1:0]    o_out_identifier,
    output logic [vrrq_pkg::HALF_W-1:0]    o_out_length,
    output logic [vrrq_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_last,
    output logic [vrrq_pkg::PCOUNT_W-1:0]  o_packet_count,
    output logic [vrrq_pkg::BUSED_W-1:0]   o_bytes_used
);

    // Pointers hold 0..STORE_BYTES; sums cover a pointer plus a full record.
    localparam int PW  = $clog2(STORE_BYTES + 1);
    localparam int AW  = $clog2(STORE_BYTES);
    localparam int CW  = $clog2(STORE_BYTES / vrrq_pkg::HEADER_BYTES + 1);
    localparam int SW  = ((PW > vrrq_pkg::HALF_W + 1) ? PW : vrrq_pkg::HALF_W + 1) + 1;
    localparam logic [SW-1:0] STORE_S  = SW'(STORE_BYTES);
    localparam logic [SW-1:0] HEADER_S = SW'(vrrq_pkg::HEADER_BYTES);
    localparam logic [PW:0]   STORE_A  = (PW+1)'(STORE_BYTES);

    // Queue state.
    logic [PW-1:0] r_wp, r_end, r_rp, r_used;
    logic [CW-1:0] r_cnt;
    logic [vrrq_pkg::HALF_W-1:0] r_ins_rem, r_rd_rem;
    logic [vrrq_pkg::HDR_IDX_W-1:0] r_k;

    // Latched transaction, header base, header capture and result staging.
    logic [vrrq_pkg::FUNC_W-1:0] r_func;
    logic [vrrq_pkg::HALF_W-1:0] r_ident, r_plen, r_cap;
    logic [vrrq_pkg::BYTE_W-1:0] r_dbyte;
    logic [PW-1:0]               r_base;
    logic [2*vrrq_pkg::HALF_W-1:0] r_hdr;
    logic [vrrq_pkg::STAT_W-1:0] r_res_status;
    logic [vrrq_pkg::HALF_W-1:0] r_res_id, r_res_len;
    logic [vrrq_pkg::BYTE_W-1:0] r_res_byte;
    logic                        r_res_last;

    logic [vrrq_pkg::STAT_W-1:0]   r_o_status;
    logic [vrrq_pkg::HALF_W-1:0]   r_o_id, r_o_len;
    logic [vrrq_pkg::BYTE_W-1:0]   r_o_byte;
    logic                          r_o_last;
    logic [vrrq_pkg::PCOUNT_W-1:0] r_o_cnt;
    logic [vrrq_pkg::BUSED_W-1:0]  r_o_used;

    // Room check for a begin insert.
    logic [SW-1:0] need, wp_need, eff_need;
    logic          wrap, room_ok;
    logic [PW-1:0] wp_eff;

    always_comb begin
        need     = HEADER_S + SW'(r_plen);
        wp_need  = SW'(r_wp) + need;
        wrap     = (r_wp == r_end) && (wp_need > STORE_S);
        wp_eff   = wrap ? '0 : r_wp;
        eff_need = SW'(wp_eff) + need;
        room_ok  = (SW'(r_used) + need <= STORE_S)
                && !(wrap && (SW'(r_rp) < need))
                && !((wp_eff < r_end) && (eff_need > SW'(r_rp)));
    end

    // Distill commit values from the captured header.
    logic [vrrq_pkg::HALF_W-1:0] hid, hlen;
    logic                        cap_ok;
    logic [SW-1:0]               rec_sz, rp_next, used_s;

    always_comb begin
        hid     = r_hdr[vrrq_pkg::HALF_W-1:0];
        hlen    = r_hdr[2*vrrq_pkg::HALF_W-1:vrrq_pkg::HALF_W];
        cap_ok  = (r_cap >= hlen);
        rec_sz  = cap_ok ? HEADER_S : HEADER_S + SW'(hlen);
        rp_next = SW'(r_rp) + rec_sz;
        used_s  = SW'(r_used);
    end

    // Byte store address, taken modulo the store size.
    logic [PW-1:0]   a_ptr;
    logic [PW:0]     a_raw, a_mod;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [vrrq_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

    always_comb begin
        a_ptr     = r_rp;
        a_raw     = {1'b0, r_rp};
        mem_we    = 1'b0;
        mem_wdata = r_dbyte;
        case (i_cmd.mem_op)
            vrrq_pkg::MEM_HDR_WR: begin
                a_ptr  = r_base;
                a_raw  = {1'b0, a_ptr} + (PW+1)'(r_k);
                mem_we = 1'b1;
                case (r_k)
                    2'd0:    mem_wdata = r_ident[7:0];
                    2'd1:    mem_wdata = r_ident[15:8];
                    2'd2:    mem_wdata = r_plen[7:0];
                    default: mem_wdata = r_plen[15:8];
                endcase
            end
            vrrq_pkg::MEM_BYTE_WR: begin
                a_ptr  = r_wp;
                a_raw  = {1'b0, a_ptr};
                mem_we = 1'b1;
            end
            vrrq_pkg::MEM_HDR_RD: begin
                a_raw = {1'b0, a_ptr} + (PW+1)'(r_k);
            end
            default: begin
                a_raw = {1'b0, a_ptr};
            end
        endcase
        a_mod    = (a_raw >= STORE_A) ? a_raw - STORE_A : a_raw;
        mem_addr = AW'(a_mod);
    end

    vrrq_ram #(
        .WIDTH (vrrq_pkg::BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Queue state updates; the controller issues one update per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_end     <= '0;
            r_rp      <= '0;
            r_used    <= '0;
            r_cnt     <= '0;
            r_ins_rem <= '0;
            r_rd_rem  <= '0;
            r_k       <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_wp      <= '0;
                r_end     <= '0;
                r_rp      <= '0;
                r_used    <= '0;
                r_cnt     <= '0;
                r_ins_rem <= '0;
                r_rd_rem  <= '0;
            end else if (i_cmd.ins_commit) begin
                r_wp <= PW'(SW'(wp_eff) + HEADER_S);
                if (eff_need > SW'(r_end)) begin
                    r_end <= PW'(eff_need);
                end
                r_used    <= PW'(used_s + need);
                r_cnt     <= r_cnt + 1'b1;
                r_ins_rem <= r_plen;
            end else if (i_cmd.mem_op == vrrq_pkg::MEM_BYTE_WR) begin
                r_wp      <= r_wp + 1'b1;
                r_ins_rem <= r_ins_rem - 1'b1;
            end else if (i_cmd.dist_wrap) begin
                if (r_rp == r_end) begin
                    r_rp  <= '0;
                    r_end <= r_wp;
                end
            end else if (i_cmd.dist_commit) begin
                r_cnt  <= r_cnt - 1'b1;
                r_rp   <= PW'(rp_next);
                r_used <= (used_s >= rec_sz) ? PW'(used_s - rec_sz) : '0;
                if (cap_ok) begin
                    r_rd_rem <= hlen;
                end
            end else if (i_cmd.byte_cap) begin
                r_rp     <= r_rp + 1'b1;
                r_rd_rem <= r_rd_rem - 1'b1;
                if (r_used != '0) begin
                    r_used <= r_used - 1'b1;
                end
            end
            // Header byte counter.
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Transaction latch, header capture, result staging and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_ident <= i_identifier;
            r_plen  <= i_packet_length;
            r_dbyte <= i_data_byte;
            r_cap   <= i_reader_capacity;
        end
        if (i_cmd.ins_commit) begin
            r_base <= wp_eff;
        end
        if (i_cmd.hdr_cap) begin
            r_hdr <= {mem_rdata, r_hdr[2*vrrq_pkg::HALF_W-1:vrrq_pkg::BYTE_W]};
        end
        if (i_cmd.res_init) begin
            r_res_status <= i_cmd.res_status;
            r_res_id     <= '0;
            r_res_len    <= '0;
            r_res_byte   <= '0;
            r_res_last   <= 1'b0;
        end
        if (i_cmd.dist_commit) begin
            r_res_id  <= hid;
            r_res_len <= cap_ok ? hlen : '0;
        end
        if (i_cmd.byte_cap) begin
            r_res_byte <= mem_rdata;
            r_res_last <= (r_rd_rem == vrrq_pkg::HALF_W'(1));
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_res_status;
            r_o_id     <= r_res_id;
            r_o_len    <= r_res_len;
            r_o_byte   <= r_res_byte;
            r_o_last   <= r_res_last;
            r_o_cnt    <= vrrq_pkg::PCOUNT_W'(r_cnt);
            r_o_used   <= vrrq_pkg::BUSED_W'(r_used);
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.func     = r_func;
        o_stat.ins_pend = (r_ins_rem != '0);
        o_stat.rd_pend  = (r_rd_rem != '0);
        o_stat.empty    = (r_used == '0) || (r_cnt == '0);
        o_stat.room_ok  = room_ok;
        o_stat.k_zero   = (r_k == '0);
        o_stat.k_last   = (r_k == vrrq_pkg::HDR_IDX_W'(vrrq_pkg::HEADER_BYTES - 1));
    end

    assign o_status         = r_o_status;
    assign o_out_identifier = r_o_id;
    assign o_out_length     = r_o_len;
    assign o_out_byte       = r_o_byte;
    assign o_last           = r_o_last;
    assign o_packet_count   = r_o_cnt;
    assign o_bytes_used     = r_o_used;

endmodule

/* rtl/vrrq_ctrl.sv */
// Controller: sequences each transaction through the datapath and the output slot.
module vrrq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  vrrq_pkg::t_stat i_stat,
    output vrrq_pkg::t_cmd  o_cmd
);

    vrrq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and output slot registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vrrq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.mem_op     = vrrq_pkg::MEM_NONE;
        o_cmd.res_status = vrrq_pkg::STATUS_OK;
        o_in_ready       = 1'b0;

        unique case (r_state)
            vrrq_pkg::S_IDLE: begin
                // No transaction is taken while reset is held.
                o_in_ready  = i_rst_n;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = vrrq_pkg::S_EXEC;
                end
            end
            vrrq_pkg::S_EXEC: begin
                o_cmd.res_init = 1'b1;
                o_cmd.k_clr    = 1'b1;
                n_state        = vrrq_pkg::S_FIN;
                case (i_stat.func)
                    vrrq_pkg::FUNC_BEGIN: begin
                        if (i_stat.ins_pend) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_SEQ;
                        end else if (!i_stat.room_ok) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_NOROOM;
                        end else begin
                            o_cmd.ins_commit = 1'b1;
                            n_state          = vrrq_pkg::S_HDR_WR;
                        end
                    end
                    vrrq_pkg::FUNC_IBYTE: begin
                        if (!i_stat.ins_pend) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_SEQ;
                        end else begin
                            o_cmd.mem_op = vrrq_pkg::MEM_BYTE_WR;
                        end
                    end
                    vrrq_pkg::FUNC_DIST: begin
                        if (i_stat.ins_pend || i_stat.rd_pend) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_SEQ;
                        end else if (i_stat.empty) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_EMPTY;
                        end else begin
                            o_cmd.dist_wrap = 1'b1;
                            n_state         = vrrq_pkg::S_HDR_RD;
                        end
                    end
                    vrrq_pkg::FUNC_RBYTE: begin
                        if (!i_stat.rd_pend) begin
                            o_cmd.res_status = vrrq_pkg::STATUS_SEQ;
                        end else begin
                            o_cmd.mem_op = vrrq_pkg::MEM_BYTE_RD;
                            n_state      = vrrq_pkg::S_BYTE_CAP;
                        end
                    end
                    vrrq_pkg::FUNC_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        o_cmd.res_status = vrrq_pkg::STATUS_SEQ;
                    end
                endcase
            end
            vrrq_pkg::S_HDR_WR: begin
                o_cmd.mem_op = vrrq_pkg::MEM_HDR_WR;
                o_cmd.k_inc  = 1'b1;
                if (i_stat.k_last) begin
                    n_state = vrrq_pkg::S_FIN;
                end
            end
            vrrq_pkg::S_HDR_RD: begin
                // Read data is registered, so capture trails the address.
                o_cmd.mem_op  = vrrq_pkg::MEM_HDR_RD;
                o_cmd.k_inc   = 1'b1;
                o_cmd.hdr_cap = !i_stat.k_zero;
                if (i_stat.k_last) begin
                    n_state = vrrq_pkg::S_HDR_LAST;
                end
            end
            vrrq_pkg::S_HDR_LAST: begin
                o_cmd.hdr_cap = 1'b1;
                n_state       = vrrq_pkg::S_DIST_COMMIT;
            end
            vrrq_pkg::S_DIST_COMMIT: begin
                o_cmd.dist_commit = 1'b1;
                n_state           = vrrq_pkg::S_FIN;
            end
            vrrq_pkg::S_BYTE_CAP: begin
                o_cmd.byte_cap = 1'b1;
                n_state        = vrrq_pkg::S_FIN;
            end
            vrrq_pkg::S_FIN: begin
                // Move the result into the output slot once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = vrrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vrrq_pkg::S_IDLE;
            end
        endcase
    end

    // Output slot occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
